### hdl/per_flow_fixed_window_rate_limiter_core_assert.svh
// Assertion macros, clocked on clk, disabled while rst_n is low.
`ifndef PER_FLOW_FIXED_WINDOW_RATE_LIMITER_CORE_ASSERT_SVH
`define PER_FLOW_FIXED_WINDOW_RATE_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PFWRL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFWRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pfwrl_pkg.sv
package pfwrl_pkg;

    localparam int RULE_ENTRIES_DEFAULT = 16;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_CHECK = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    typedef enum logic [2:0] {
        ST_PASS_UNMATCHED = 3'd0,
        ST_PASS_COUNTED   = 3'd1,
        ST_PASS_RESTART   = 3'd2,
        ST_REJECTED       = 3'd3,
        ST_STORED         = 3'd4,
        ST_FULL           = 3'd5,
        ST_TICKED         = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_CHECK,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] kind;
        logic [31:0] addr;
        logic [15:0] secs;
        logic [15:0] calls;
    } q_word_t;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] limit;
        logic [31:0] start;
        logic [31:0] count;
    } entry_t;

    typedef enum logic {
        B_IDLE,
        B_EXEC
    } bstate_t;

endpackage

### hdl/pfwrl_req_if.sv
interface pfwrl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] request_kind;
    logic [31:0] source_address;
    logic [15:0] limit_seconds;
    logic [15:0] limit_calls;

    modport source (
        output valid, mode, request_kind, source_address, limit_seconds, limit_calls,
        input  ready
    );
    modport sink (
        input  valid, mode, request_kind, source_address, limit_seconds, limit_calls,
        output ready
    );
endinterface

### hdl/pfwrl_rsp_if.sv
interface pfwrl_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] call_count;

    modport source (
        output valid, status, call_count,
        input  ready
    );
    modport sink (
        input  valid, status, call_count,
        output ready
    );
endinterface

### hdl/pfwrl_front.sv
module pfwrl_front
    import pfwrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pfwrl_req_if.sink  req,
    output logic       q_valid,
    output q_word_t    q_word,
    input  logic       q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_word_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               push, pop;
    q_word_t            in_word;

    // classify
    always_comb
    begin
        in_word.kind  = req.request_kind;
        in_word.addr  = req.source_address;
        in_word.secs  = req.limit_seconds;
        in_word.calls = req.limit_calls;
        case (req.mode)
            MODE_STORE: in_word.op = OP_STORE;
            MODE_CHECK: in_word.op = OP_CHECK;
            MODE_TICK:  in_word.op = OP_TICK;
            default:    in_word.op = OP_NONE;
        endcase
    end

    assign req.ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (fill_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_word    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

### hdl/pfwrl_back.sv
`include "per_flow_fixed_window_rate_limiter_core_assert.svh"

module pfwrl_back
    import pfwrl_pkg::*;
#(
    parameter int RULE_ENTRIES = RULE_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  q_word_t     q_word,
    output logic        q_pop,
    pfwrl_rsp_if.source rsp
);

    localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;

    bstate_t                 state_reg, state_next;
    logic [RULE_ENTRIES-1:0] valid_reg;
    logic [15:0]             kind_reg [RULE_ENTRIES];
    logic [31:0]             addr_reg [RULE_ENTRIES];
    entry_t                  mem [RULE_ENTRIES];
    entry_t                  rd_reg;
    logic [31:0]             seconds_reg;

    q_word_t                 cmd_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    hit_reg;
    logic                    full_reg;

    logic                    out_valid_reg;
    status_t                 status_reg, status_next;
    logic [31:0]             count_reg, count_next;

    logic [RULE_ENTRIES-1:0] match_vec;
    logic [IDX_W-1:0]        hit_idx, free_idx, sel_idx;
    logic                    any_hit, any_free;
    logic                    match_go, exec_go;
    logic                    mem_wr, key_wr, tick_go;
    entry_t                  wr_entry;
    logic [31:0]             elapsed, count_inc;
    logic                    expired;

    // parallel key match
    always_comb
    begin
        for (int i = 0; i < RULE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (kind_reg[i] == q_word.kind)
                           && (addr_reg[i] == q_word.addr);
        end
        hit_idx  = '0;
        free_idx = '0;
        for (int i = RULE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        any_hit  = |match_vec;
        any_free = ~&valid_reg;
        sel_idx  = (q_word.op == OP_STORE && !any_hit) ? free_idx : hit_idx;
    end

    // execute
    always_comb
    begin
        elapsed   = seconds_reg - rd_reg.start;
        expired   = elapsed > {16'd0, rd_reg.window};
        count_inc = (&rd_reg.count) ? rd_reg.count : rd_reg.count + 32'd1;

        status_next = ST_PASS_UNMATCHED;
        count_next  = '0;
        mem_wr      = 1'b0;
        key_wr      = 1'b0;
        tick_go     = 1'b0;
        wr_entry    = rd_reg;

        case (cmd_reg.op)
            OP_STORE:
            begin
                if (full_reg)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next     = ST_STORED;
                    mem_wr          = 1'b1;
                    key_wr          = 1'b1;
                    wr_entry.window = cmd_reg.secs;
                    wr_entry.limit  = cmd_reg.calls;
                    wr_entry.start  = seconds_reg;
                    wr_entry.count  = '0;
                end
            end
            OP_CHECK:
            begin
                if (hit_reg)
                begin
                    mem_wr = 1'b1;
                    if (expired)
                    begin
                        status_next    = ST_PASS_RESTART;
                        wr_entry.start = seconds_reg;
                        wr_entry.count = '0;
                    end
                    else
                    begin
                        status_next    = (count_inc > {16'd0, rd_reg.limit})
                                         ? ST_REJECTED : ST_PASS_COUNTED;
                        wr_entry.count = count_inc;
                        count_next     = count_inc;
                    end
                end
            end
            OP_TICK:
            begin
                status_next = ST_TICKED;
                tick_go     = 1'b1;
            end
            default:
            begin
                status_next = ST_PASS_UNMATCHED;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        match_go   = 1'b0;
        exec_go    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    match_go   = 1'b1;
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    exec_go    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign q_pop          = match_go;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.call_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            seconds_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_go && key_wr)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (exec_go && tick_go)
            begin
                seconds_reg <= seconds_reg + 32'd1;
            end
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_go)
        begin
            cmd_reg  <= q_word;
            idx_reg  <= sel_idx;
            hit_reg  <= any_hit;
            full_reg <= !any_hit && !any_free;
        end
        if (exec_go)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
        end
        if (exec_go && key_wr)
        begin
            kind_reg[idx_reg] <= cmd_reg.kind;
            addr_reg[idx_reg] <= cmd_reg.addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_go)
        begin
            rd_reg <= mem[sel_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && mem_wr)
        begin
            mem[idx_reg] <= wr_entry;
        end
    end

    `PFWRL_ASSERT_SAME(a_full_no_free, state_reg == B_EXEC && cmd_reg.op == OP_STORE && full_reg, &valid_reg, "store reported full with a free entry")
    `PFWRL_ASSERT_SAME(a_hit_valid, state_reg == B_EXEC && hit_reg, valid_reg[idx_reg], "matched entry is not valid")
    `PFWRL_ASSERT_NEXT(a_tick_step, exec_go && tick_go, seconds_reg == $past(seconds_reg) + 32'd1, "tick did not advance clock by one")
    `PFWRL_ASSERT_NEXT(a_exec_after_pop, q_pop, state_reg == B_EXEC, "popped word not executed")

endmodule

### hdl/per_flow_fixed_window_rate_limiter_core.sv
// Channel  Dir  Fields                                                          Accept
// req      in   mode, request_kind, source_address, limit_seconds, limit_calls  valid && ready
// rsp      out  status, call_count                                              valid && ready
//
// Each word passes two back-end steps: a key match that addresses the entry memory,
// then an update that writes back a stored or matched entry and loads the result register.
// The back end matches no new word until the update of the last one is done.
// A two-word queue sits in front; req.ready drops only when it is full.
// A held result stalls the update cycle until rsp.ready; the queue keeps accepting.
// Reset clears the rule valid bits and the seconds clock at once; no clearing pass.
module per_flow_fixed_window_rate_limiter_core
    import pfwrl_pkg::*;
#(
    parameter int RULE_ENTRIES = RULE_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    pfwrl_req_if.sink   req,
    pfwrl_rsp_if.source rsp
);

    logic    q_valid;
    logic    q_pop;
    q_word_t q_word;

    pfwrl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    pfwrl_back #(
        .RULE_ENTRIES (RULE_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import pfwrl_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         TABLE_SIZE   = RULE_ENTRIES_DEFAULT;
    localparam int         KEY_POOL     = TABLE_SIZE + 8;
    localparam int         RANDOM_WORDS = 1500;
    localparam int         CHUNK_WORDS  = 100;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         REPORT_LIMIT = 10;
    localparam int         CYCLE_LIMIT  = 400000;

    typedef struct {
        status_t     status;
        logic [31:0] count;
    } verdict_t;

    logic clk;
    logic rst_n;

    pfwrl_req_if req_ch ();
    pfwrl_rsp_if rsp_ch ();

    per_flow_fixed_window_rate_limiter_core #(
        .RULE_ENTRIES (TABLE_SIZE)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [31:0] clock_seconds;
    logic        rule_valid  [TABLE_SIZE];
    logic [15:0] rule_kind   [TABLE_SIZE];
    logic [31:0] rule_addr   [TABLE_SIZE];
    logic [15:0] rule_window [TABLE_SIZE];
    logic [15:0] rule_limit  [TABLE_SIZE];
    logic [31:0] rule_start  [TABLE_SIZE];
    logic [31:0] rule_count  [TABLE_SIZE];

    verdict_t    expected_verdicts[$];

    logic [15:0] pool_kind [KEY_POOL];
    logic [31:0] pool_addr [KEY_POOL];

    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned status_seen [8];
    int          req_idle_style;
    int          rsp_idle_style;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(input int style);
        int r;
        if (style == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int find_rule(input logic [15:0] kind, input logic [31:0] addr);
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (rule_valid[i] && rule_kind[i] == kind && rule_addr[i] == addr)
                return i;
        end
        return -1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (!rule_valid[i])
                return i;
        end
        return -1;
    endfunction

    function automatic void predict_verdict(input logic [1:0] md, input logic [15:0] kind,
                                            input logic [31:0] addr, input logic [15:0] secs,
                                            input logic [15:0] calls);
        verdict_t    v;
        int          slot;
        logic [31:0] elapsed;
        v.status = ST_PASS_UNMATCHED;
        v.count  = '0;
        case (md)
            MODE_STORE:
            begin
                slot = find_rule(kind, addr);
                if (slot < 0)
                    slot = first_free();
                if (slot < 0)
                    v.status = ST_FULL;
                else
                begin
                    rule_valid[slot]  = 1'b1;
                    rule_kind[slot]   = kind;
                    rule_addr[slot]   = addr;
                    rule_window[slot] = secs;
                    rule_limit[slot]  = calls;
                    rule_start[slot]  = clock_seconds;
                    rule_count[slot]  = '0;
                    v.status          = ST_STORED;
                end
            end
            MODE_CHECK:
            begin
                slot = find_rule(kind, addr);
                if (slot >= 0)
                begin
                    elapsed = clock_seconds - rule_start[slot];
                    if (elapsed > {16'd0, rule_window[slot]})
                    begin
                        rule_start[slot] = clock_seconds;
                        rule_count[slot] = '0;
                        v.status         = ST_PASS_RESTART;
                    end
                    else
                    begin
                        if (rule_count[slot] != '1)
                            rule_count[slot] = rule_count[slot] + 32'd1;
                        if (rule_count[slot] > {16'd0, rule_limit[slot]})
                            v.status = ST_REJECTED;
                        else
                            v.status = ST_PASS_COUNTED;
                    end
                    v.count = rule_count[slot];
                end
            end
            MODE_TICK:
            begin
                clock_seconds = clock_seconds + 32'd1;
                v.status      = ST_TICKED;
            end
            default:
            begin
            end
        endcase
        expected_verdicts.push_back(v);
    endfunction

    task automatic send_word(input logic [1:0] md, input logic [15:0] kind,
                             input logic [31:0] addr, input logic [15:0] secs,
                             input logic [15:0] calls);
        int gap;
        gap = pick_gap(req_idle_style);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid          = 1'b1;
        req_ch.mode           = md;
        req_ch.request_kind   = kind;
        req_ch.source_address = addr;
        req_ch.limit_seconds  = secs;
        req_ch.limit_calls    = calls;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_verdict(md, kind, addr, secs, calls);
        words_sent++;
    endtask

    task automatic test_basic_admission();
        req_idle_style = 1;
        rsp_idle_style = 1;
        send_word(MODE_CHECK, 16'h0000, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
        send_word(MODE_STORE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        send_word(MODE_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        send_word(MODE_STORE, 16'h0000, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
        send_word(MODE_CHECK, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000);
        send_word(MODE_UNUSED, 16'hA5A5, 32'h5A5A_A5A5, 16'h5A5A, 16'hA5A5);
    endtask

    task automatic test_window_expiry();
        req_idle_style = 0;
        rsp_idle_style = 0;
        send_word(MODE_STORE, 16'h0001, 32'h0A00_0005, 16'd1, 16'd1);
        send_word(MODE_CHECK, 16'h0001, 32'h0A00_0005, 16'd0, 16'd0);
        send_word(MODE_CHECK, 16'h0001, 32'h0A00_0005, 16'd0, 16'd0);
        send_word(MODE_TICK, 16'h0000, 32'h0000_0000, 16'd0, 16'd0);
        send_word(MODE_CHECK, 16'h0001, 32'h0A00_0005, 16'd0, 16'd0);
        send_word(MODE_TICK, 16'h0000, 32'h0000_0000, 16'd0, 16'd0);
        send_word(MODE_CHECK, 16'h0001, 32'h0A00_0005, 16'd0, 16'd0);
        send_word(MODE_CHECK, 16'h0001, 32'h0A00_0005, 16'd0, 16'd0);
    endtask

    task automatic test_table_full();
        int n;
        req_idle_style = 1;
        rsp_idle_style = 0;
        n = 0;
        while (first_free() >= 0)
        begin
            send_word(MODE_STORE, 16'h0100 + 16'(n), 32'hC0A8_0000 + 32'(n), 16'd3, 16'd2);
            n++;
        end
        send_word(MODE_STORE, 16'h7777, 32'h0102_0304, 16'd9, 16'd9);
        send_word(MODE_CHECK, 16'h7777, 32'h0102_0304, 16'd0, 16'd0);
        send_word(MODE_STORE, 16'h0000, 32'h0000_0000, 16'd2, 16'd1);
    endtask

    task automatic test_random_traffic();
        int          r;
        int          k;
        logic [15:0] secs;
        logic [15:0] calls;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            pool_kind[i] = rule_kind[i];
            pool_addr[i] = rule_addr[i];
        end
        for (int i = TABLE_SIZE; i < KEY_POOL; i++)
        begin
            pool_kind[i] = 16'($urandom);
            pool_addr[i] = $urandom;
        end
        for (int w = 0; w < RANDOM_WORDS; w++)
        begin
            if (w % CHUNK_WORDS == 0)
            begin
                req_idle_style = $urandom_range(0, 1);
                rsp_idle_style = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            k = $urandom_range(0, KEY_POOL - 1);
            if ($urandom_range(0, 4) == 0)
            begin
                secs  = 16'($urandom);
                calls = 16'($urandom);
            end
            else
            begin
                secs  = 16'($urandom_range(0, 6));
                calls = 16'($urandom_range(0, 5));
            end
            if (r < 45)
                send_word(MODE_CHECK, pool_kind[k], pool_addr[k], secs, calls);
            else if (r < 55)
                send_word(MODE_CHECK, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
            else if (r < 70)
                send_word(MODE_TICK, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
            else if (r < 85)
                send_word(MODE_STORE, pool_kind[k], pool_addr[k], secs, calls);
            else if (r < 95)
                send_word(MODE_STORE, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
            else
                send_word(MODE_UNUSED, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ch.ready = 1'b1;
            stall_left   = pick_gap(rsp_idle_style);
        end
    end

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_checked++;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d count %0d",
                             rsp_ch.status, rsp_ch.call_count);
            end
            else
            begin
                v = expected_verdicts.pop_front();
                status_seen[v.status]++;
                if (rsp_ch.status !== v.status || rsp_ch.call_count !== v.count)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch on result %0d: expected status %0d count %0d, got status %0d count %0d",
                                 results_checked, v.status, v.count,
                                 rsp_ch.status, rsp_ch.call_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.mode           = MODE_STORE;
        req_ch.request_kind   = '0;
        req_ch.source_address = '0;
        req_ch.limit_seconds  = '0;
        req_ch.limit_calls    = '0;
        rsp_ch.ready          = 1'b0;
        stall_left            = 0;
        req_idle_style        = 0;
        rsp_idle_style        = 0;
        words_sent            = 0;
        results_checked       = 0;
        mismatches            = 0;
        cycle_count           = 0;
        clock_seconds         = '0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
            rule_valid[i] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_admission();
        test_window_expiry();
        test_table_full();
        test_random_traffic();

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d results checked, seconds clock at %0d",
                 words_sent, results_checked, clock_seconds);
        $display("unmatched %0d, counted %0d, restarted %0d, rejected %0d, stored %0d, full %0d, ticks %0d",
                 status_seen[ST_PASS_UNMATCHED], status_seen[ST_PASS_COUNTED],
                 status_seen[ST_PASS_RESTART], status_seen[ST_REJECTED],
                 status_seen[ST_STORED], status_seen[ST_FULL], status_seen[ST_TICKED]);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
